// ===== design/rqa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the region quota accounting block: field widths, command and
// pressure codes, register indexes and the structs passed between modules.
// No dependencies.
package rqa_pkg;

   localparam int LIMIT_W     = 48;
   localparam int RATIO_W     = 17;
   localparam int COUNT_W     = 48;
   localparam int TOTAL_W     = 64;
   localparam int EVOUT_W     = 32;
   localparam int REGION_W    = 2;
   localparam int CMD_W       = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 48;

   localparam logic [RATIO_W-1:0] RATIO_ONE   = 17'd65536;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd52429;

   // register map: four limits, then four ratios
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_BASE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_BASE = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_END        = 4'd8;

   localparam logic [1:0] PRESS_NORMAL = 2'd0;
   localparam logic [1:0] PRESS_HIGH   = 2'd1;
   localparam logic [1:0] PRESS_HARD   = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESERVE    = 3'd0,
      CMD_COMMIT     = 3'd1,
      CMD_CANCEL     = 3'd2,
      CMD_FREE       = 3'd3,
      CMD_CORRUPTION = 3'd4,
      CMD_QUERY      = 3'd5
   } rqa_cmd_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit;
      logic [LIMIT_W-1:0] mark;
   } rqa_quota_type;

   typedef struct packed {
      logic               granted;
      logic [1:0]         pressure;
      logic [COUNT_W-1:0] live_bytes;
      logic [COUNT_W-1:0] peak_bytes;
      logic [TOTAL_W-1:0] allocated_total;
      logic [TOTAL_W-1:0] freed_total;
      logic [EVOUT_W-1:0] alloc_events;
      logic [EVOUT_W-1:0] free_events;
      logic [EVOUT_W-1:0] corrupt_events;
      logic [EVOUT_W-1:0] rejected_events;
   } rqa_result_type;

endpackage

// ===== design/rqa_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers: per-region hard limit and watermark ratio, plus the
// registered high-watermark byte mark derived from them. Uses rqa_pkg.
module rqa_csr #(
   parameter int REGION_COUNT = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [rqa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rqa_pkg::CSR_DATA_W-1:0]    csr_data,
   output rqa_pkg::rqa_quota_type            quota [REGION_COUNT]
);
   import rqa_pkg::*;

   logic [LIMIT_W-1:0] limit_ff [REGION_COUNT];
   logic [RATIO_W-1:0] ratio_ff [REGION_COUNT];
   logic [LIMIT_W-1:0] mark_ff  [REGION_COUNT];
   logic [LIMIT_W-1:0] mark_in  [REGION_COUNT];

   logic is_limit;
   logic is_ratio;

   assign is_limit = csr_write && (csr_index >= CSR_LIMIT_BASE) && (csr_index < CSR_RATIO_BASE);
   assign is_ratio = csr_write && (csr_index >= CSR_RATIO_BASE) && (csr_index < CSR_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REGION_COUNT; r++) begin
            limit_ff[r] <= '0;
            ratio_ff[r] <= RATIO_RESET;
         end
      end else begin
         for (int r = 0; r < REGION_COUNT; r++) begin
            if (is_limit && csr_index[1:0] == 2'(r)) begin
               limit_ff[r] <= csr_data[LIMIT_W-1:0];
            end
            if (is_ratio && csr_index[1:0] == 2'(r)) begin
               ratio_ff[r] <= csr_data[RATIO_W-1:0];
            end
         end
      end
   end

   // mark = floor(limit * min(ratio, 1.0)); never exceeds the limit
   always_comb begin
      logic [RATIO_W-1:0]         ratio_sat;
      logic [LIMIT_W+RATIO_W-1:0] product;
      for (int r = 0; r < REGION_COUNT; r++) begin
         ratio_sat  = (ratio_ff[r] > RATIO_ONE) ? RATIO_ONE : ratio_ff[r];
         product    = (LIMIT_W+RATIO_W)'(limit_ff[r]) * (LIMIT_W+RATIO_W)'(ratio_sat);
         mark_in[r] = product[LIMIT_W+15:16];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < REGION_COUNT; r++) begin
         mark_ff[r] <= mark_in[r];
      end
   end

   always_comb begin
      for (int r = 0; r < REGION_COUNT; r++) begin
         quota[r].limit = limit_ff[r];
         quota[r].mark  = mark_ff[r];
      end
   end

endmodule

// ===== design/rqa_core.sv =====
`timescale 1ns / 1ps
// Per-region accounting state and the single-pass update for one command word.
// Produces the result word combinationally from the registered command. Uses rqa_pkg.
module rqa_core #(
   parameter int REGION_COUNT = 4,
   parameter int BYTE_WIDTH   = 48,
   parameter int EVENT_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [rqa_pkg::CMD_W-1:0]       cmd,
   input  logic [rqa_pkg::REGION_W-1:0]    region,
   input  logic [rqa_pkg::COUNT_W-1:0]     byte_count,
   input  rqa_pkg::rqa_quota_type          quota [REGION_COUNT],
   output rqa_pkg::rqa_result_type         result
);
   import rqa_pkg::*;

   localparam int RIDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam int MW     = (BYTE_WIDTH > LIMIT_W) ? BYTE_WIDTH : LIMIT_W;
   localparam int EW     = (EVENT_WIDTH > EVOUT_W) ? EVENT_WIDTH : EVOUT_W;
   localparam logic [BYTE_WIDTH-1:0] BYTE_MAX = {BYTE_WIDTH{1'b1}};

   logic [BYTE_WIDTH-1:0]  active_ff    [REGION_COUNT];
   logic [BYTE_WIDTH-1:0]  peak_ff      [REGION_COUNT];
   logic [TOTAL_W-1:0]     alloc_tot_ff [REGION_COUNT];
   logic [TOTAL_W-1:0]     freed_tot_ff [REGION_COUNT];
   logic [EVENT_WIDTH-1:0] alloc_ev_ff  [REGION_COUNT];
   logic [EVENT_WIDTH-1:0] free_ev_ff   [REGION_COUNT];
   logic [EVENT_WIDTH-1:0] corrupt_ev_ff[REGION_COUNT];
   logic [EVENT_WIDTH-1:0] reject_ev_ff [REGION_COUNT];

   logic [BYTE_WIDTH-1:0]  active_in;
   logic [BYTE_WIDTH-1:0]  peak_in;
   logic [TOTAL_W-1:0]     alloc_tot_in;
   logic [TOTAL_W-1:0]     freed_tot_in;
   logic [EVENT_WIDTH-1:0] alloc_ev_in;
   logic [EVENT_WIDTH-1:0] free_ev_in;
   logic [EVENT_WIDTH-1:0] corrupt_ev_in;
   logic [EVENT_WIDTH-1:0] reject_ev_in;
   logic                   granted;

   logic [RIDX_W-1:0]      idx;
   logic                   in_range;
   logic [MW-1:0]          cnt_wide;
   logic [BYTE_WIDTH-1:0]  cnt;
   logic [BYTE_WIDTH-1:0]  act;
   logic [LIMIT_W-1:0]     lim;
   logic [LIMIT_W-1:0]     mark;
   logic [MW-1:0]          cap;
   logic [MW:0]            sum;
   logic                   fits;
   logic [BYTE_WIDTH-1:0]  act_sub;

   assign in_range = int'(region) < REGION_COUNT;
   assign idx      = region[RIDX_W-1:0];
   assign cnt_wide = MW'(byte_count);
   assign cnt      = cnt_wide[BYTE_WIDTH-1:0];
   assign act      = active_ff[idx];
   assign lim      = quota[idx].limit;
   assign mark     = quota[idx].mark;
   assign cap      = (lim == '0) ? MW'(BYTE_MAX) : MW'(lim);
   assign sum      = (MW+1)'(act) + (MW+1)'(cnt);
   assign fits     = (sum <= (MW+1)'(cap)) && (sum <= (MW+1)'(BYTE_MAX));
   assign act_sub  = (act > cnt) ? (act - cnt) : '0;

   always_comb begin
      active_in     = act;
      peak_in       = peak_ff[idx];
      alloc_tot_in  = alloc_tot_ff[idx];
      freed_tot_in  = freed_tot_ff[idx];
      alloc_ev_in   = alloc_ev_ff[idx];
      free_ev_in    = free_ev_ff[idx];
      corrupt_ev_in = corrupt_ev_ff[idx];
      reject_ev_in  = reject_ev_ff[idx];
      granted       = 1'b0;
      unique case (cmd)
         CMD_RESERVE: begin
            if (fits) begin
               active_in = sum[BYTE_WIDTH-1:0];
               granted   = 1'b1;
               if (sum[BYTE_WIDTH-1:0] > peak_ff[idx]) begin
                  peak_in = sum[BYTE_WIDTH-1:0];
               end
            end else begin
               reject_ev_in = reject_ev_ff[idx] + 1'b1;
            end
         end
         CMD_COMMIT: begin
            alloc_tot_in = alloc_tot_ff[idx] + TOTAL_W'(cnt);
            alloc_ev_in  = alloc_ev_ff[idx] + 1'b1;
         end
         CMD_CANCEL: begin
            active_in = act_sub;
         end
         CMD_FREE: begin
            active_in    = act_sub;
            freed_tot_in = freed_tot_ff[idx] + TOTAL_W'(cnt);
            free_ev_in   = free_ev_ff[idx] + 1'b1;
         end
         CMD_CORRUPTION: begin
            corrupt_ev_in = corrupt_ev_ff[idx] + 1'b1;
         end
         default: begin
            // query and unused codes leave the region untouched
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REGION_COUNT; r++) begin
            active_ff[r]     <= '0;
            peak_ff[r]       <= '0;
            alloc_tot_ff[r]  <= '0;
            freed_tot_ff[r]  <= '0;
            alloc_ev_ff[r]   <= '0;
            free_ev_ff[r]    <= '0;
            corrupt_ev_ff[r] <= '0;
            reject_ev_ff[r]  <= '0;
         end
      end else if (step && in_range) begin
         active_ff[idx]     <= active_in;
         peak_ff[idx]       <= peak_in;
         alloc_tot_ff[idx]  <= alloc_tot_in;
         freed_tot_ff[idx]  <= freed_tot_in;
         alloc_ev_ff[idx]   <= alloc_ev_in;
         free_ev_ff[idx]    <= free_ev_in;
         corrupt_ev_ff[idx] <= corrupt_ev_in;
         reject_ev_ff[idx]  <= reject_ev_in;
      end
   end

   // level from the post-step active total
   always_comb begin
      logic [MW-1:0] act_w;
      logic [MW-1:0] peak_w;
      logic [EW-1:0] ev_alloc_w;
      logic [EW-1:0] ev_free_w;
      logic [EW-1:0] ev_corrupt_w;
      logic [EW-1:0] ev_reject_w;
      logic [1:0]    level;
      act_w        = MW'(active_in);
      peak_w       = MW'(peak_in);
      ev_alloc_w   = EW'(alloc_ev_in);
      ev_free_w    = EW'(free_ev_in);
      ev_corrupt_w = EW'(corrupt_ev_in);
      ev_reject_w  = EW'(reject_ev_in);
      if (lim == '0) begin
         level = PRESS_NORMAL;
      end else if (act_w >= MW'(lim)) begin
         level = PRESS_HARD;
      end else if (act_w >= MW'(mark)) begin
         level = PRESS_HIGH;
      end else begin
         level = PRESS_NORMAL;
      end
      result = '0;
      if (in_range) begin
         result.granted         = granted;
         result.pressure        = level;
         result.live_bytes      = act_w[COUNT_W-1:0];
         result.peak_bytes      = peak_w[COUNT_W-1:0];
         result.allocated_total = alloc_tot_in;
         result.freed_total     = freed_tot_in;
         result.alloc_events    = ev_alloc_w[EVOUT_W-1:0];
         result.free_events     = ev_free_w[EVOUT_W-1:0];
         result.corrupt_events  = ev_corrupt_w[EVOUT_W-1:0];
         result.rejected_events = ev_reject_w[EVOUT_W-1:0];
      end
   end

endmodule

// ===== design/region_quota_accounting_top.sv =====
`timescale 1ns / 1ps
// Region quota accounting top level: command register, accounting core, result register.
// An accepted command word goes through the command register, then the result register.
// Throughput: 1 word per cycle while rsp_stall is low; one add/compare pass per update.
// Config writes take effect for a command word accepted on the next cycle or later.
// Reset (synchronous): all region counters cleared, limits 0 (unlimited),
// ratios 52429 (about 0.8); both stages empty.
module region_quota_accounting_top #(
   parameter int REGION_COUNT = 4,
   parameter int BYTE_WIDTH   = 48,
   parameter int EVENT_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rqa_pkg::CMD_W-1:0]       req_cmd,
   input  logic [rqa_pkg::REGION_W-1:0]    req_region,
   input  logic [rqa_pkg::COUNT_W-1:0]     req_byte_count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_granted,
   output logic [1:0]                      rsp_pressure,
   output logic [rqa_pkg::COUNT_W-1:0]     rsp_active_bytes_out,
   output logic [rqa_pkg::COUNT_W-1:0]     rsp_peak_bytes_out,
   output logic [rqa_pkg::TOTAL_W-1:0]     rsp_allocated_total_out,
   output logic [rqa_pkg::TOTAL_W-1:0]     rsp_freed_total_out,
   output logic [rqa_pkg::EVOUT_W-1:0]     rsp_alloc_events_out,
   output logic [rqa_pkg::EVOUT_W-1:0]     rsp_free_events_out,
   output logic [rqa_pkg::EVOUT_W-1:0]     rsp_corruption_events_out,
   output logic [rqa_pkg::EVOUT_W-1:0]     rsp_rejected_events_out,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rqa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rqa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rqa_pkg::*;

   rqa_quota_type  quota [REGION_COUNT];
   rqa_result_type result;
   rqa_result_type result_ff;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [REGION_W-1:0] region_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic                advance;
   logic                accept;
   logic                step;

   assign csr_ready = 1'b1;

   // the command stage moves whenever the result register is free or draining
   assign advance      = !out_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign step         = in_valid_ff && advance;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         region_ff <= req_region;
         count_ff  <= req_byte_count;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   rqa_csr #(
      .REGION_COUNT (REGION_COUNT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .quota     (quota)
   );

   rqa_core #(
      .REGION_COUNT (REGION_COUNT),
      .BYTE_WIDTH   (BYTE_WIDTH),
      .EVENT_WIDTH  (EVENT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (cmd_ff),
      .region     (region_ff),
      .byte_count (count_ff),
      .quota      (quota),
      .result     (result)
   );

   assign rsp_valid                 = out_valid_ff;
   assign rsp_granted               = result_ff.granted;
   assign rsp_pressure              = result_ff.pressure;
   assign rsp_active_bytes_out      = result_ff.live_bytes;
   assign rsp_peak_bytes_out        = result_ff.peak_bytes;
   assign rsp_allocated_total_out   = result_ff.allocated_total;
   assign rsp_freed_total_out       = result_ff.freed_total;
   assign rsp_alloc_events_out      = result_ff.alloc_events;
   assign rsp_free_events_out       = result_ff.free_events;
   assign rsp_corruption_events_out = result_ff.corrupt_events;
   assign rsp_rejected_events_out   = result_ff.rejected_events;

   // active bytes only rise through a granted reserve, which also lifts the peak
   a_peak_covers_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_bytes_out >= rsp_active_bytes_out))
      else $error("peak bytes below active bytes");

   // a request is held back only by a blocked result word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while result path is free");

   // a word in the command stage that advances shows up as a result
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("advanced command word produced no result");

   // the level is always one of normal, high or hard
   a_pressure_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pressure <= PRESS_HARD))
      else $error("invalid pressure level on result word");

endmodule
